[sv/csc_pkg.sv]
// Shared types and constants for the cycling speed and cadence decoder.
`timescale 1ns / 1ps
package csc_pkg;
    localparam int FrameLength = 11;
    localparam logic [9:0] CircReset = 10'd217;
    localparam int FlagWheel = 0;
    localparam int FlagCrank = 1;

    // Decoded frame handed from the front end to the back end
    typedef struct packed {
        logic [31:0] wc;
        logic [15:0] wt;
        logic [15:0] cc;
        logic [15:0] ct;
        logic [31:0] now;
    } frame_t;

    // Result fields
    typedef struct packed {
        logic [22:0] ride_time_s;
        logic [31:0] distance_cm;
        logic        riding;
        logic [15:0] cadence_rpm;
        logic [15:0] speed_kmh_x10;
    } result_t;
endpackage

[sv/cycling_speed_cadence_decoder_top.sv]
// Top level of the cycling speed and cadence decoder.
// Usage:
//   s_axis: one notification byte per transaction. tdata carries data_byte
//   in bits [7:0] and now_ms in bits [39:8]; tlast marks the final byte.
//   m_axis: one result transaction per 11-byte frame; frames of other
//   lengths give nothing. cfg: writes the wheel circumference in cm.
// Throughput: one byte per cycle while bytes arrive and the front is not
//   stalled. Decode of a frame in the back end is bounded by two 56-step serial
//   divisions (speed then cadence) in one shared divider.
//   The first frame after reset runs no division.
// A one-entry frame register between front and back lets the front keep
//   collecting the next frame while the back works; the front stalls all
//   input while that register holds a frame the back has not yet taken.
// Reset clears all totals and history; circumference returns to 217.
// If m_axis stalls, the result stays held and the back end waits.
`timescale 1ns / 1ps
module cycling_speed_cadence_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], now_ms[39:8]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // speed[15:0], cadence[31:16], riding[32],
                                        // distance[64:33], ride_time_s[87:65]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);
    import csc_pkg::*;

    logic [9:0] circ_reg;
    logic       fr_valid;
    logic       fr_ready;
    frame_t     fr_data;
    result_t    res;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = res;

    // Hold circumference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg <= CircReset;
        end
        else if (cfg_valid)
        begin
            circ_reg <= cfg_data;
        end
    end

    csc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .data_byte (s_axis_tdata[7:0]),
        .last_byte (s_axis_tlast),
        .now_ms    (s_axis_tdata[39:8]),
        .fr_valid  (fr_valid),
        .fr_ready  (fr_ready),
        .fr_data   (fr_data)
    );

    csc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .circ      (circ_reg),
        .fr_valid  (fr_valid),
        .fr_ready  (fr_ready),
        .fr_data   (fr_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (res)
    );
endmodule

[sv/csc_front.sv]
// Front end: collects notification bytes, checks length, extracts fields.
`timescale 1ns / 1ps
module csc_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     data_byte,
    input  logic           last_byte,
    input  logic [31:0]    now_ms,
    output logic           fr_valid,
    input  logic           fr_ready,
    output csc_pkg::frame_t fr_data
);
    import csc_pkg::*;

    logic [3:0]  byte_index_reg;
    logic        overflow_reg;
    logic [7:0]  bytes_reg [FrameLength];
    logic        fr_valid_reg;
    frame_t      fr_data_reg;
    logic        take;
    logic        store;
    logic [7:0]  b [FrameLength];
    logic [7:0]  flags;
    frame_t      dec;

    assign in_ready = !fr_valid_reg || fr_ready;
    assign take     = in_valid && in_ready;
    assign store    = !overflow_reg && (byte_index_reg < 4'(FrameLength));
    assign fr_valid = fr_valid_reg;
    assign fr_data  = fr_data_reg;

    // View of the frame with the final byte in place
    always_comb
    begin
        for (int i = 0; i < FrameLength; i++)
        begin
            b[i] = bytes_reg[i];
        end
        b[FrameLength-1] = data_byte;
        flags = b[0];
        dec = '0;
        dec.now = now_ms;
        if (flags[FlagWheel])
        begin
            dec.wc = {b[4], b[3], b[2], b[1]};
            dec.wt = {b[6], b[5]};
            if (flags[FlagCrank])
            begin
                dec.cc = {b[8], b[7]};
                dec.ct = {b[10], b[9]};
            end
        end
        else if (flags[FlagCrank])
        begin
            dec.cc = {b[2], b[1]};
            dec.ct = {b[4], b[3]};
        end
    end

    // Store bytes
    always_ff @(posedge clk)
    begin
        if (take && store)
        begin
            bytes_reg[byte_index_reg] <= data_byte;
        end
    end

    // Track position and emit good frames
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            overflow_reg   <= 1'b0;
            fr_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fr_valid_reg && fr_ready)
            begin
                fr_valid_reg <= 1'b0;
            end
            if (take)
            begin
                if (last_byte)
                begin
                    byte_index_reg <= '0;
                    overflow_reg   <= 1'b0;
                    if (store && byte_index_reg == 4'(FrameLength - 1))
                    begin
                        fr_valid_reg <= 1'b1;
                    end
                end
                else if (store)
                begin
                    byte_index_reg <= byte_index_reg + 4'd1;
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last_byte)
        begin
            fr_data_reg <= dec;
        end
    end
endmodule

[sv/csc_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module csc_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [55:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [55:0] quotient
);
    logic [55:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [33:0] diff;

    assign shifted  = {r_reg[31:0], q_reg[55]};
    assign diff     = {1'b0, shifted} - {2'b0, d_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    // Shift and subtract
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd55;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                r_reg <= diff[32:0];
                q_reg <= {q_reg[54:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[54:0], 1'b0};
            end
        end
    end
endmodule

[sv/csc_back.sv]
// Back end: differences, accumulators, speed and cadence division, result register.
`timescale 1ns / 1ps
module csc_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [9:0]      circ,
    input  logic            fr_valid,
    output logic            fr_ready,
    input  csc_pkg::frame_t fr_data,
    output logic            res_valid,
    input  logic            res_ready,
    output csc_pkg::result_t res_data
);
    import csc_pkg::*;

    // Reciprocal of 1000 scaled by 2^38, exact for every 32-bit dividend
    localparam logic [28:0] MsToSec = 29'h10624DD3;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIFF  = 9'b000000010,
        S_MUL1  = 9'b000000100,
        S_MUL2  = 9'b000001000,
        S_SPD   = 9'b000010000,
        S_CAD   = 9'b000100000,
        S_DIST  = 9'b001000000,
        S_SEC   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t      state_reg;
    logic        have_prev_reg;
    frame_t      prev_reg;
    frame_t      cur_reg;
    logic [31:0] total_rev_reg;
    logic [31:0] total_ms_reg;
    logic [15:0] cadence_reg;
    logic [15:0] speed_reg;
    logic        riding_reg;
    logic [31:0] dwc_reg;
    logic [15:0] dwt_reg;
    logic [15:0] dcc_reg;
    logic [15:0] dct_reg;
    logic [41:0] cd_reg;
    logic [41:0] dist_reg;
    logic [60:0] sec_prod_reg;
    logic        res_valid_reg;
    result_t     res_reg;
    logic        div_start;
    logic [55:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [55:0] div_q;
    logic [32:0] rev_sum;
    logic [32:0] ms_sum;

    assign fr_ready  = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign rev_sum   = {1'b0, total_rev_reg} + {1'b0, dwc_reg};
    assign ms_sum    = {1'b0, total_ms_reg} + {1'b0, cur_reg.now - prev_reg.now};

    csc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Launch divisions
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = 56'(cd_reg) * 56'd9216;
        div_divisor  = 32'(dwt_reg) * 32'd25;
        case (state_reg)
            S_MUL2:
            begin
                div_start = (dwt_reg != '0);
            end
            S_SPD:
            begin
                if (div_done || dwt_reg == '0)
                begin
                    div_start    = (dct_reg != '0);
                    div_dividend = 56'(dcc_reg) * 56'd61440;
                    div_divisor  = 32'(dct_reg);
                end
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Sequence one frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            total_rev_reg <= '0;
            total_ms_reg  <= '0;
            cadence_reg   <= '0;
            speed_reg     <= '0;
            riding_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (fr_valid)
                    begin
                        state_reg <= have_prev_reg ? S_DIFF : S_DIST;
                    end
                end
                S_DIFF:
                begin
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    riding_reg    <= (dwc_reg != '0);
                    total_rev_reg <= rev_sum[32] ? '1 : rev_sum[31:0];
                    if (dwc_reg != '0)
                    begin
                        total_ms_reg <= ms_sum[32] ? '1 : ms_sum[31:0];
                    end
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_SPD;
                end
                S_SPD:
                begin
                    if (dwt_reg == '0)
                    begin
                        speed_reg <= '0;
                        state_reg <= S_CAD;
                    end
                    else if (div_done)
                    begin
                        speed_reg <= (div_q > 56'hFFFF) ? 16'hFFFF : div_q[15:0];
                        state_reg <= S_CAD;
                    end
                end
                S_CAD:
                begin
                    if (dct_reg == '0)
                    begin
                        state_reg <= S_DIST;
                    end
                    else if (div_done)
                    begin
                        cadence_reg <= (div_q > 56'hFFFF) ? 16'hFFFF : div_q[15:0];
                        state_reg   <= S_DIST;
                    end
                end
                S_DIST:
                begin
                    prev_reg      <= cur_reg;
                    have_prev_reg <= 1'b1;
                    state_reg     <= S_SEC;
                end
                S_SEC:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cur_reg <= fr_data;
            end
            S_DIFF:
            begin
                dwc_reg <= cur_reg.wc - prev_reg.wc;
                dwt_reg <= cur_reg.wt - prev_reg.wt;
                dcc_reg <= cur_reg.cc - prev_reg.cc;
                dct_reg <= cur_reg.ct - prev_reg.ct;
            end
            S_MUL1:
            begin
                cd_reg <= 42'(circ) * 42'(dwc_reg);
            end
            S_DIST:
            begin
                dist_reg <= 42'(circ) * 42'(total_rev_reg);
            end
            S_SEC:
            begin
                sec_prod_reg <= 61'(total_ms_reg) * 61'(MsToSec);
            end
            S_OUT:
            begin
                // Load the whole result only once the previous one has left
                if (!res_valid_reg || res_ready)
                begin
                    res_reg.distance_cm   <= (dist_reg > 42'hFFFFFFFF) ? '1 : dist_reg[31:0];
                    res_reg.ride_time_s   <= sec_prod_reg[60:38];
                    res_reg.speed_kmh_x10 <= speed_reg;
                    res_reg.cadence_rpm   <= cadence_reg;
                    res_reg.riding        <= riding_reg;
                end
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end
endmodule
